FILE: rtl/tdr_pkg.sv
// shared types and constants of the triangle depth rasterizer
package tdr_pkg;

    // item kinds
    localparam logic [1:0] KIND_DRAW  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;   // unused kind, answered with zeros

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // far depth, the reset value of the depth store
    localparam logic signed [23:0] DEPTH_FAR = 24'sh800000;

    // datapath widths
    localparam int BOX_W  = 14;   // signed pixel coordinates of the bounding box
    localparam int EDGE_W = 40;   // edge functions and doubled area
    localparam int K_W    = 43;   // depth gradient terms
    localparam int NUM_W  = 64;   // interpolated depth numerator
    localparam int QUOT_W = 24;   // interpolated depth

endpackage

FILE: rtl/tdr_if.sv
// item channels of the triangle depth rasterizer
interface tdr_cmd_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  kind;
    logic signed [15:0] vertex_a_x;
    logic signed [15:0] vertex_a_y;
    logic signed [23:0] vertex_a_z;
    logic signed [15:0] vertex_b_x;
    logic signed [15:0] vertex_b_y;
    logic signed [23:0] vertex_b_z;
    logic signed [15:0] vertex_c_x;
    logic signed [15:0] vertex_c_y;
    logic signed [23:0] vertex_c_z;
    logic        [23:0] fill_color;
    logic        [15:0] read_index;

    modport source (
        output valid, kind, vertex_a_x, vertex_a_y, vertex_a_z,
               vertex_b_x, vertex_b_y, vertex_b_z,
               vertex_c_x, vertex_c_y, vertex_c_z, fill_color, read_index,
        input  ready
    );
    modport sink (
        input  valid, kind, vertex_a_x, vertex_a_y, vertex_a_z,
               vertex_b_x, vertex_b_y, vertex_b_z,
               vertex_c_x, vertex_c_y, vertex_c_z, fill_color, read_index,
        output ready
    );
endinterface

interface tdr_rsp_if;
    logic               valid;
    logic               ready;
    logic        [23:0] pixel_color;
    logic signed [23:0] pixel_depth;
    logic        [16:0] pixels_written;

    modport source (
        output valid, pixel_color, pixel_depth, pixels_written,
        input  ready
    );
    modport sink (
        input  valid, pixel_color, pixel_depth, pixels_written,
        output ready
    );
endinterface

FILE: rtl/tdr_div.sv
// iterative signed divider, one quotient bit per cycle, truncates toward zero
module tdr_div
    import tdr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [NUM_W-1:0]  num,
    input  logic signed [EDGE_W-1:0] den,
    output logic                     done,
    output logic signed [QUOT_W-1:0] quot
);

    localparam int CNT_W = $clog2(QUOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] q_reg;
    logic [NUM_W-1:0]  num_mag;
    logic [NUM_W-1:0]  den_mag;
    logic              fits;

    // operand magnitudes
    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_mag = den[EDGE_W-1] ? NUM_W'(-den) : NUM_W'(den);
    assign fits    = rem_reg >= dsh_reg;

    // restoring division, divisor walks down from the top quotient bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= num_mag;
                dsh_reg  <= den_mag << (QUOT_W - 1);
                neg_reg  <= num[NUM_W-1] ^ den[EDGE_W-1];
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg   <= {q_reg[QUOT_W-2:0], fits};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? QUOT_W'(-q_reg) : q_reg;

endmodule

FILE: rtl/triangle_depth_rasterizer.sv
// top level: triangle rasterizer with depth test over color and depth stores
//
// cmd carries one item per valid/ready handshake: a draw, a read or a clear.
// rsp returns exactly one item for each command; it holds until taken and
// the next command is accepted while a result still waits in rsp.
// cfg_we/cfg_index/cfg_data write frame_width (index 0) and frame_height
// (index 1); write them only while the block is idle.
// After reset, and for every clear item, a pass writes far depth and color 0
// to all MAX_WIDTH*MAX_HEIGHT entries, one a cycle; no command is taken meanwhile.
// A draw runs its setup on one shared 27x18 multiply-accumulate unit, then
// walks the bounding box; each covered pixel waits for the bit-serial divider
// that produces the 24 depth bits. A read goes through S_READ and S_RFIN, a
// clear through the pass, before S_DONE places the result.
// One command is in work at a time; cmd.ready is low until its result is
// placed in the output register, which a stalled receiver only holds.
module triangle_depth_rasterizer
    import tdr_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    tdr_cmd_if.sink    cmd,
    tdr_rsp_if.source  rsp,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data
);

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int OP_LAST    = 15;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_RFIN, S_SETUP, S_MUL,
        S_TEST, S_DIV, S_CMP, S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [8:0]  frame_width_reg;
    logic [8:0]  frame_height_reg;
    logic [12:0] w_eff;
    logic [12:0] h_eff;

    // latched command
    logic signed [15:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [23:0] az_reg, bz_reg, cz_reg;
    logic [23:0]        color_reg;

    // triangle setup
    logic signed [16:0]       d_bcy_reg, d_cbx_reg, d_cay_reg, d_acx_reg, d_aycy_reg;
    logic signed [24:0]       dza_reg, dzb_reg;
    logic signed [17:0]       pxo_reg, pyo_reg;
    logic signed [BOX_W-1:0]  x0_reg, x1_reg, y0_reg, y1_reg;
    logic signed [BOX_W-1:0]  x_reg, y_reg;
    logic [3:0]               op_reg;
    logic signed [NUM_W-1:0]  acc_reg;
    logic signed [EDGE_W-1:0] area_reg;
    logic signed [K_W-1:0]    kx_reg, ky_reg;

    // walk state
    logic signed [EDGE_W-1:0] ea_reg, eb_reg, ea_row_reg, eb_row_reg;
    logic signed [NUM_W-1:0]  n_reg, n_row_reg;
    logic [AW-1:0]            row_base_reg;
    logic signed [QUOT_W-1:0] z_reg;

    // stores
    logic signed [23:0] depth_mem [STORE_SIZE];
    logic [23:0]        color_mem [STORE_SIZE];
    logic signed [23:0] depth_q;
    logic [23:0]        color_q;
    logic [AW-1:0]      rd_addr_reg;
    logic               rd_oob_reg;
    logic [AW-1:0]      sweep_reg;
    logic               clr_item_reg;

    // results
    logic [23:0]        res_color_reg;
    logic signed [23:0] res_depth_reg;
    logic [16:0]        written_reg;
    logic               rsp_valid_reg;
    logic [23:0]        rsp_color_reg;
    logic signed [23:0] rsp_depth_reg;
    logic [16:0]        rsp_written_reg;

    // effective frame size, saturated to the store size
    always_comb
    begin
        w_eff = (13'(frame_width_reg) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH)
                                                         : 13'(frame_width_reg);
        h_eff = (13'(frame_height_reg) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT)
                                                           : 13'(frame_height_reg);
    end

    // bounding box from the latched vertices
    logic signed [15:0]      min_x, max_x, min_y, max_y;
    logic signed [BOX_W-1:0] bx0, bx1, by0, by1;
    logic signed [16:0]      qx, qy;

    always_comb
    begin
        min_x = (ax_reg < bx_reg) ? ax_reg : bx_reg;
        min_x = (min_x < cx_reg) ? min_x : cx_reg;
        max_x = (ax_reg > bx_reg) ? ax_reg : bx_reg;
        max_x = (max_x > cx_reg) ? max_x : cx_reg;
        min_y = (ay_reg < by_reg) ? ay_reg : by_reg;
        min_y = (min_y < cy_reg) ? min_y : cy_reg;
        max_y = (ay_reg > by_reg) ? ay_reg : by_reg;
        max_y = (max_y > cy_reg) ? max_y : cy_reg;
        bx0 = min_x[15] ? '0 : BOX_W'(min_x >>> 4);
        by0 = min_y[15] ? '0 : BOX_W'(min_y >>> 4);
        // division by 16 truncates toward zero
        qx = max_x[15] ? ((17'(max_x) + 17'sd15) >>> 4) : (17'(max_x) >>> 4);
        qy = max_y[15] ? ((17'(max_y) + 17'sd15) >>> 4) : (17'(max_y) >>> 4);
        bx1 = BOX_W'(qx) + BOX_W'(2);
        by1 = BOX_W'(qy) + BOX_W'(2);
        if (bx1 > $signed({1'b0, w_eff}))
        begin
            bx1 = $signed({1'b0, w_eff});
        end
        if (by1 > $signed({1'b0, h_eff}))
        begin
            by1 = $signed({1'b0, h_eff});
        end
    end

    // shared multiply-accumulate unit, operands picked by the setup step
    logic signed [26:0]      mul_a;
    logic signed [17:0]      mul_b;
    logic [4:0]              mul_sh;
    logic                    mul_first;
    logic signed [44:0]      mul_p;
    logic signed [NUM_W-1:0] acc_next;

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mul_sh    = 5'd0;
        mul_first = 1'b0;
        case (op_reg)
            4'd0:  begin mul_a = 27'(d_bcy_reg); mul_b = 18'(d_acx_reg);  mul_first = 1'b1; end
            4'd1:  begin mul_a = 27'(d_cbx_reg); mul_b = 18'(d_aycy_reg); end
            4'd2:  begin mul_a = 27'(d_bcy_reg); mul_b = pxo_reg;         mul_first = 1'b1; end
            4'd3:  begin mul_a = 27'(d_cbx_reg); mul_b = pyo_reg;         end
            4'd4:  begin mul_a = 27'(d_cay_reg); mul_b = pxo_reg;         mul_first = 1'b1; end
            4'd5:  begin mul_a = 27'(d_acx_reg); mul_b = pyo_reg;         end
            4'd6:  begin mul_a = 27'(dza_reg);   mul_b = 18'(d_bcy_reg);  mul_first = 1'b1; end
            4'd7:  begin mul_a = 27'(dzb_reg);   mul_b = 18'(d_cay_reg);  end
            4'd8:  begin mul_a = 27'(dza_reg);   mul_b = 18'(d_cbx_reg);  mul_first = 1'b1; end
            4'd9:  begin mul_a = 27'(dzb_reg);   mul_b = 18'(d_acx_reg);  end
            4'd10:
            begin
                mul_a = $signed({5'b0, kx_reg[21:0]}); mul_b = pxo_reg; mul_first = 1'b1;
            end
            4'd11:
            begin
                mul_a = 27'($signed(kx_reg[K_W-1:22])); mul_b = pxo_reg; mul_sh = 5'd22;
            end
            4'd12: begin mul_a = $signed({5'b0, ky_reg[21:0]}); mul_b = pyo_reg; end
            4'd13:
            begin
                mul_a = 27'($signed(ky_reg[K_W-1:22])); mul_b = pyo_reg; mul_sh = 5'd22;
            end
            4'd14: begin mul_a = 27'(cz_reg); mul_b = $signed({1'b0, area_reg[16:0]}); end
            default:
            begin
                mul_a = 27'(cz_reg); mul_b = $signed(area_reg[34:17]); mul_sh = 5'd17;
            end
        endcase
        mul_p    = mul_a * mul_b;
        acc_next = (mul_first ? '0 : acc_reg) + (NUM_W'(mul_p) <<< mul_sh);
    end

    // coverage of the current pixel center, edges inclusive
    logic signed [EDGE_W-1:0] ec;
    logic                     area_pos;
    logic                     covered;
    logic [AW-1:0]            pix_addr;

    always_comb
    begin
        ec       = area_reg - ea_reg - eb_reg;
        area_pos = !area_reg[EDGE_W-1];
        if (area_pos)
        begin
            covered = !ea_reg[EDGE_W-1] && !eb_reg[EDGE_W-1] && !ec[EDGE_W-1];
        end
        else
        begin
            covered = (ea_reg[EDGE_W-1] || ea_reg == '0)
                   && (eb_reg[EDGE_W-1] || eb_reg == '0)
                   && (ec[EDGE_W-1] || ec == '0);
        end
        pix_addr = row_base_reg + AW'(x_reg);
    end

    // divider for the interpolated depth
    logic div_start;
    logic div_done;
    logic signed [QUOT_W-1:0] div_quot;

    assign div_start = (state_reg == S_TEST) && covered;

    tdr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (n_reg),
        .den   (area_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // store write port
    logic               wr_en;
    logic               nearer;
    logic [AW-1:0]      wr_addr;
    logic signed [23:0] wr_depth;
    logic [23:0]        wr_color;
    logic               adv;

    always_comb
    begin
        nearer   = z_reg > depth_q;
        wr_en    = (state_reg == S_CLEAR) || ((state_reg == S_CMP) && nearer);
        wr_addr  = (state_reg == S_CLEAR) ? sweep_reg : rd_addr_reg;
        wr_depth = (state_reg == S_CLEAR) ? DEPTH_FAR : z_reg;
        wr_color = (state_reg == S_CLEAR) ? 24'd0 : color_reg;
        adv      = ((state_reg == S_TEST) && !covered) || (state_reg == S_CMP);
    end

    // depth and color stores
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            depth_mem[wr_addr] <= wr_depth;
            color_mem[wr_addr] <= wr_color;
        end
        depth_q <= depth_mem[rd_addr_reg];
        color_q <= color_mem[rd_addr_reg];
    end

    // row base of the first bounding box row
    logic [24:0] row_base_full;
    assign row_base_full = 25'(y0_reg[10:0]) * 25'(w_eff);

    // sequencer, setup and walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            sweep_reg        <= '0;
            clr_item_reg     <= 1'b0;
            frame_width_reg  <= 9'd256;
            frame_height_reg <= 9'd256;
            rsp_valid_reg    <= 1'b0;
            op_reg           <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                endcase
            end

            // result taken while no new one is placed
            if (rsp_valid_reg && rsp.ready && state_reg != S_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == AW'(STORE_SIZE - 1))
                    begin
                        state_reg <= clr_item_reg ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        ax_reg        <= cmd.vertex_a_x;
                        ay_reg        <= cmd.vertex_a_y;
                        az_reg        <= cmd.vertex_a_z;
                        bx_reg        <= cmd.vertex_b_x;
                        by_reg        <= cmd.vertex_b_y;
                        bz_reg        <= cmd.vertex_b_z;
                        cx_reg        <= cmd.vertex_c_x;
                        cy_reg        <= cmd.vertex_c_y;
                        cz_reg        <= cmd.vertex_c_z;
                        color_reg     <= cmd.fill_color;
                        res_color_reg <= '0;
                        res_depth_reg <= '0;
                        written_reg   <= '0;
                        case (cmd.kind)
                            KIND_DRAW:
                            begin
                                state_reg <= S_SETUP;
                            end
                            KIND_READ:
                            begin
                                rd_addr_reg <= AW'(cmd.read_index);
                                rd_oob_reg  <= 25'(cmd.read_index) >= 25'(STORE_SIZE);
                                state_reg   <= S_READ;
                            end
                            KIND_CLEAR:
                            begin
                                sweep_reg    <= '0;
                                clr_item_reg <= 1'b1;
                                state_reg    <= S_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_RFIN;
                end
                S_RFIN:
                begin
                    if (!rd_oob_reg)
                    begin
                        res_color_reg <= color_q;
                        res_depth_reg <= depth_q;
                    end
                    state_reg <= S_DONE;
                end
                S_SETUP:
                begin
                    d_bcy_reg  <= 17'(by_reg) - 17'(cy_reg);
                    d_cbx_reg  <= 17'(cx_reg) - 17'(bx_reg);
                    d_cay_reg  <= 17'(cy_reg) - 17'(ay_reg);
                    d_acx_reg  <= 17'(ax_reg) - 17'(cx_reg);
                    d_aycy_reg <= 17'(ay_reg) - 17'(cy_reg);
                    dza_reg    <= 25'(az_reg) - 25'(cz_reg);
                    dzb_reg    <= 25'(bz_reg) - 25'(cz_reg);
                    x0_reg     <= bx0;
                    x1_reg     <= bx1;
                    y0_reg     <= by0;
                    y1_reg     <= by1;
                    x_reg      <= bx0;
                    y_reg      <= by0;
                    op_reg     <= '0;
                    state_reg  <= S_MUL;
                end
                S_MUL:
                begin
                    acc_reg <= acc_next;
                    op_reg  <= op_reg + 1'b1;
                    case (op_reg)
                        4'd0:
                        begin
                            // pixel center of the box corner relative to vertex c
                            pxo_reg      <= (18'(x0_reg) <<< 4) + 18'sd8 - 18'(cx_reg);
                            pyo_reg      <= (18'(y0_reg) <<< 4) + 18'sd8 - 18'(cy_reg);
                            row_base_reg <= AW'(row_base_full);
                        end
                        4'd1: area_reg <= EDGE_W'(acc_next);
                        4'd3:
                        begin
                            ea_reg     <= EDGE_W'(acc_next);
                            ea_row_reg <= EDGE_W'(acc_next);
                        end
                        4'd5:
                        begin
                            eb_reg     <= EDGE_W'(acc_next);
                            eb_row_reg <= EDGE_W'(acc_next);
                        end
                        4'd7: kx_reg <= K_W'(acc_next);
                        4'd9: ky_reg <= K_W'(acc_next);
                        default: ;
                    endcase
                    if (op_reg == 4'(OP_LAST))
                    begin
                        n_reg     <= acc_next;
                        n_row_reg <= acc_next;
                        if (area_reg == '0 || x0_reg >= x1_reg || y0_reg >= y1_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_TEST;
                        end
                    end
                end
                S_TEST:
                begin
                    if (covered)
                    begin
                        rd_addr_reg <= pix_addr;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        z_reg     <= div_quot;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (nearer)
                    begin
                        written_reg <= written_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg   <= 1'b1;
                        rsp_color_reg   <= res_color_reg;
                        rsp_depth_reg   <= res_depth_reg;
                        rsp_written_reg <= written_reg;
                        clr_item_reg    <= 1'b0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // step to the next pixel of the bounding box
            if (adv)
            begin
                if (x_reg + BOX_W'(1) < x1_reg)
                begin
                    x_reg     <= x_reg + BOX_W'(1);
                    ea_reg    <= ea_reg + (EDGE_W'(d_bcy_reg) <<< 4);
                    eb_reg    <= eb_reg + (EDGE_W'(d_cay_reg) <<< 4);
                    n_reg     <= n_reg + (NUM_W'(kx_reg) <<< 4);
                    state_reg <= S_TEST;
                end
                else if (y_reg + BOX_W'(1) < y1_reg)
                begin
                    x_reg        <= x0_reg;
                    y_reg        <= y_reg + BOX_W'(1);
                    row_base_reg <= row_base_reg + AW'(w_eff);
                    ea_row_reg   <= ea_row_reg + (EDGE_W'(d_cbx_reg) <<< 4);
                    eb_row_reg   <= eb_row_reg + (EDGE_W'(d_acx_reg) <<< 4);
                    n_row_reg    <= n_row_reg + (NUM_W'(ky_reg) <<< 4);
                    ea_reg       <= ea_row_reg + (EDGE_W'(d_cbx_reg) <<< 4);
                    eb_reg       <= eb_row_reg + (EDGE_W'(d_acx_reg) <<< 4);
                    n_reg        <= n_row_reg + (NUM_W'(ky_reg) <<< 4);
                    state_reg    <= S_TEST;
                end
                else
                begin
                    state_reg <= S_DONE;
                end
            end
        end
    end

    // ports
    assign cmd.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.pixel_color    = rsp_color_reg;
    assign rsp.pixel_depth    = rsp_depth_reg;
    assign rsp.pixels_written = rsp_written_reg;

    // checks
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the depth wait");

    a_cmp_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> $past(div_done))
        else $error("depth compare without a fresh quotient");

    a_walk_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TEST |-> (x_reg < x1_reg && y_reg < y1_reg))
        else $error("pixel walk left the bounding box");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside the done step");

endmodule
